// ===== design/butterworth_lowpass_with_minimum_detect_core_macros.svh =====
// Assertion macros shared by the checker of the low-pass core.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef BUTTERWORTH_LOWPASS_WITH_MINIMUM_DETECT_CORE_MACROS_SVH
`define BUTTERWORTH_LOWPASS_WITH_MINIMUM_DETECT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BWLP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BWLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bwlp_pkg.sv =====
// Shared types and constants of the third-order low-pass core.
// No dependencies; every other .sv design file refers to this package by scoped names.
`timescale 1ns / 1ps

package bwlp_pkg;

  localparam int RAW_W     = 16;   // raw reading width
  localparam int GAIN_W    = 27;   // unsigned feedforward gain, Q3.24
  localparam int COEF_W    = 28;   // signed feedback coefficient, Q3.24
  localparam int OUT_W     = 32;   // filtered result width
  localparam int FRAC_W    = 16;   // fraction bits of the output history
  localparam int HIST_W    = 40;   // stored output width
  localparam int NUM_TAPS  = 3;    // feedback taps, one cell each
  localparam int CFG_IDX_W = 2;

  // Rounding: products are Q.40 (feedback) or Q.24 (feedforward), results Q.16.
  localparam int RND_SHIFT = 24;
  localparam int FF_SHIFT  = RND_SHIFT - FRAC_W;

  // The stored output is split into a signed upper half and an unsigned lower half.
  localparam int SPLIT_W   = HIST_W / 2;
  localparam int AL_W      = RND_SHIFT - SPLIT_W;
  localparam int MUL_W     = SPLIT_W + 1 + COEF_W;
  localparam int AH_W      = MUL_W - AL_W;
  localparam int REST_W    = MUL_W + 1;

  localparam int SUM_W     = RAW_W + 3;
  localparam int FF_PROD_W = SUM_W + GAIN_W + 1;
  localparam int ACC_W     = 46;

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_ONE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_TWO   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_THREE = 2'd3;

  localparam logic [GAIN_W-1:0]        GAIN_RST = 27'd15353;
  localparam logic signed [COEF_W-1:0] FB1_RST  = 28'sd43386361;
  localparam logic signed [COEF_W-1:0] FB2_RST  = -28'sd37805749;
  localparam logic signed [COEF_W-1:0] FB3_RST  = 28'sd11073784;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_temp;
    logic                    crc_ok;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered;
    logic                    at_minimum;
  } out_t;

  // Step strobes from the sequencer to the sample store and the tap cells.
  typedef struct packed {
    logic ld_prime;
    logic ld_sample;
    logic mul_hi;
    logic mul_lo;
    logic rnd_a;
    logic rnd_b;
    logic hist_shift;
  } ctl_t;

endpackage

// ===== design/butterworth_lowpass_with_minimum_detect_core.sv =====
// Third-order low-pass filter on a temperature stream with a local-minimum flag.
// Channels: in_valid/in_stall/in_data carry one reading and its CRC flag per
// request; out_valid/out_stall/out_data return exactly one result per request.
// A request is taken at a rising edge with valid high and stall low.
// cfg_we/cfg_idx/cfg_wdata write the gain and the three feedback coefficients;
// write them only while no request is in flight.
// A filter step runs through the states MULA, MULB, RNDA, RNDB, INJ, CHAIN and
// EMIT; the priming request or a bad one before priming goes straight to EMIT.
// Steps do not overlap; a filter step uses the shared multiplier in
// each tap cell (two halves), two rounding steps and the three-cell sum chain.
// A one-deep input register takes the next request while a step runs.
// Reset (rst_n low, synchronous) restores the default coefficients, clears the
// primed flag and empties the input and output registers.
// While out_stall is high the result is held; the core finishes the step in
// flight, then waits, and in_stall rises once the input register is full.
// Depends on bwlp_pkg, bwlp_samples and bwlp_tap_cell.
`timescale 1ns / 1ps

module butterworth_lowpass_with_minimum_detect_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  bwlp_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output bwlp_pkg::out_t                       out_data,
  input  logic                                 cfg_we,
  input  logic [bwlp_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [bwlp_pkg::COEF_W-1:0]          cfg_wdata
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MULA  = 8'b0000_0010,
    ST_MULB  = 8'b0000_0100,
    ST_RNDA  = 8'b0000_1000,
    ST_RNDB  = 8'b0001_0000,
    ST_INJ   = 8'b0010_0000,
    ST_CHAIN = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_t;

  localparam int LAST = bwlp_pkg::NUM_TAPS - 1;
  localparam logic signed [bwlp_pkg::ACC_W-1:0] Y_MAX =
    bwlp_pkg::ACC_W'((longint'(1) <<< (bwlp_pkg::HIST_W - 1)) - 1);
  localparam logic signed [bwlp_pkg::ACC_W-1:0] Y_MIN = -Y_MAX - 1;
  localparam logic signed [bwlp_pkg::HIST_W-1:0] O_MAX =
    bwlp_pkg::HIST_W'((longint'(1) <<< (bwlp_pkg::OUT_W - 1)) - 1);
  localparam logic signed [bwlp_pkg::HIST_W-1:0] O_MIN = -O_MAX - 1;

  state_t                               state_r;
  state_t                               state_nxt;
  logic                                 primed_r;
  logic                                 primed_nxt;
  bwlp_pkg::in_t                        in_buf_r;
  logic                                 in_buf_vld_r;
  logic                                 in_buf_vld_nxt;
  bwlp_pkg::out_t                       res_r;
  bwlp_pkg::out_t                       res_nxt;
  bwlp_pkg::out_t                       out_data_r;
  logic                                 out_valid_r;
  logic                                 out_valid_nxt;
  logic                                 out_free;
  logic                                 in_take;
  logic                                 chain_done;
  bwlp_pkg::ctl_t                       ctl;

  logic [bwlp_pkg::GAIN_W-1:0]          gain_r;
  logic signed [bwlp_pkg::COEF_W-1:0]   coef_r [bwlp_pkg::NUM_TAPS];

  logic signed [bwlp_pkg::ACC_W-1:0]    ff_term;
  logic signed [bwlp_pkg::HIST_W-1:0]   prime_val;
  logic signed [bwlp_pkg::HIST_W-1:0]   y_new;
  logic signed [bwlp_pkg::ACC_W-1:0]    acc_fin;
  logic                                 minimum;

  logic signed [bwlp_pkg::HIST_W-1:0]   y_in    [bwlp_pkg::NUM_TAPS];
  logic signed [bwlp_pkg::HIST_W-1:0]   y_out   [bwlp_pkg::NUM_TAPS];
  logic signed [bwlp_pkg::ACC_W-1:0]    acc_in  [bwlp_pkg::NUM_TAPS];
  logic signed [bwlp_pkg::ACC_W-1:0]    acc_out [bwlp_pkg::NUM_TAPS];
  logic                                 acc_vld_in  [bwlp_pkg::NUM_TAPS];
  logic                                 acc_vld_out [bwlp_pkg::NUM_TAPS];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r    <= bwlp_pkg::GAIN_RST;
      coef_r[0] <= bwlp_pkg::FB1_RST;
      coef_r[1] <= bwlp_pkg::FB2_RST;
      coef_r[2] <= bwlp_pkg::FB3_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        bwlp_pkg::CFG_INPUT_GAIN:     gain_r    <= cfg_wdata[bwlp_pkg::GAIN_W-1:0];
        bwlp_pkg::CFG_FEEDBACK_ONE:   coef_r[0] <= $signed(cfg_wdata);
        bwlp_pkg::CFG_FEEDBACK_TWO:   coef_r[1] <= $signed(cfg_wdata);
        bwlp_pkg::CFG_FEEDBACK_THREE: coef_r[2] <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign in_stall = in_buf_vld_r;
  assign in_take  = (state_r == ST_IDLE) && in_buf_vld_r;
  assign out_free = !out_valid_r || !out_stall;
  assign chain_done = (state_r == ST_CHAIN) && acc_vld_out[LAST];

  always_comb begin
    ctl.ld_prime   = in_take && !primed_r && in_buf_r.crc_ok;
    ctl.ld_sample  = in_take && primed_r && in_buf_r.crc_ok;
    ctl.mul_hi     = (state_r == ST_MULA);
    ctl.mul_lo     = (state_r == ST_MULB);
    ctl.rnd_a      = (state_r == ST_RNDA);
    ctl.rnd_b      = (state_r == ST_RNDB);
    ctl.hist_shift = chain_done;
  end

  bwlp_samples u_samples (
    .clk     (clk),
    .ctl     (ctl),
    .x       (in_buf_r.raw_temp),
    .gain    (gain_r),
    .ff_term (ff_term)
  );

  assign prime_val = bwlp_pkg::HIST_W'($signed({in_buf_r.raw_temp,
                                                {bwlp_pkg::FRAC_W{1'b0}}}));

  // The partial sum walks from cell to cell, each adding its own feedback term.
  for (genvar k = 0; k < bwlp_pkg::NUM_TAPS; k++) begin : g_tap
    if (k == 0) begin : g_head
      assign y_in[k]       = y_new;
      assign acc_in[k]     = ff_term;
      assign acc_vld_in[k] = (state_r == ST_INJ);
    end else begin : g_body
      assign y_in[k]       = y_out[k-1];
      assign acc_in[k]     = acc_out[k-1];
      assign acc_vld_in[k] = acc_vld_out[k-1];
    end

    bwlp_tap_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .coef        (coef_r[k]),
      .y_in        (y_in[k]),
      .load_val    (prime_val),
      .y_out       (y_out[k]),
      .acc_in      (acc_in[k]),
      .acc_vld_in  (acc_vld_in[k]),
      .acc_out     (acc_out[k]),
      .acc_vld_out (acc_vld_out[k])
    );
  end

  always_comb begin
    acc_fin = acc_out[LAST];
    if (acc_fin > Y_MAX) begin
      y_new = bwlp_pkg::HIST_W'(Y_MAX);
    end else if (acc_fin < Y_MIN) begin
      y_new = bwlp_pkg::HIST_W'(Y_MIN);
    end else begin
      y_new = bwlp_pkg::HIST_W'(acc_fin);
    end
    // The previous output is a minimum when it is below the new one and not
    // above the one before it.
    minimum = (y_new > y_out[0]) && (y_out[0] <= y_out[1]);
  end

  always_comb begin
    state_nxt  = state_r;
    primed_nxt = primed_r;
    res_nxt    = res_r;
    case (state_r)
      ST_IDLE: begin
        if (in_buf_vld_r) begin
          if (primed_r) begin
            state_nxt = ST_MULA;
          end else begin
            state_nxt = ST_EMIT;
            if (in_buf_r.crc_ok) begin
              primed_nxt         = 1'b1;
              res_nxt.filtered   = $signed({in_buf_r.raw_temp, {bwlp_pkg::FRAC_W{1'b0}}});
              res_nxt.at_minimum = 1'b0;
            end else begin
              res_nxt = '0;
            end
          end
        end
      end
      ST_MULA:  state_nxt = ST_MULB;
      ST_MULB:  state_nxt = ST_RNDA;
      ST_RNDA:  state_nxt = ST_RNDB;
      ST_RNDB:  state_nxt = ST_INJ;
      ST_INJ:   state_nxt = ST_CHAIN;
      ST_CHAIN: begin
        if (chain_done) begin
          state_nxt = ST_EMIT;
          if (y_new > O_MAX) begin
            res_nxt.filtered = bwlp_pkg::OUT_W'(O_MAX);
          end else if (y_new < O_MIN) begin
            res_nxt.filtered = bwlp_pkg::OUT_W'(O_MIN);
          end else begin
            res_nxt.filtered = bwlp_pkg::OUT_W'(y_new);
          end
          res_nxt.at_minimum = minimum;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_buf_vld_nxt = in_buf_vld_r;
    if (in_valid && !in_buf_vld_r) begin
      in_buf_vld_nxt = 1'b1;
    end else if (in_take) begin
      in_buf_vld_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if ((state_r == ST_EMIT) && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      primed_r     <= 1'b0;
      in_buf_vld_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      primed_r     <= primed_nxt;
      in_buf_vld_r <= in_buf_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_buf_vld_r) begin
      in_buf_r <= in_data;
    end
    res_r <= res_nxt;
    if ((state_r == ST_EMIT) && out_free) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/bwlp_samples.sv =====
// Sample history and feedforward term of the low-pass core.
// Depends on bwlp_pkg for widths and the step strobe struct.
`timescale 1ns / 1ps

module bwlp_samples (
  input  logic                                  clk,
  input  bwlp_pkg::ctl_t                        ctl,
  input  logic signed [bwlp_pkg::RAW_W-1:0]     x,
  input  logic [bwlp_pkg::GAIN_W-1:0]           gain,
  output logic signed [bwlp_pkg::ACC_W-1:0]     ff_term
);

  localparam int DEPTH = bwlp_pkg::NUM_TAPS + 1;
  localparam logic signed [bwlp_pkg::FF_PROD_W-1:0] FF_HALF =
    bwlp_pkg::FF_PROD_W'(1) <<< (bwlp_pkg::FF_SHIFT - 1);

  logic signed [bwlp_pkg::RAW_W-1:0]     smp_r [DEPTH];
  logic signed [bwlp_pkg::SUM_W-1:0]     pair;
  logic signed [bwlp_pkg::SUM_W-1:0]     sum_nxt;
  logic signed [bwlp_pkg::SUM_W-1:0]     sum_r;
  logic signed [bwlp_pkg::FF_PROD_W-1:0] prod_nxt;
  logic signed [bwlp_pkg::FF_PROD_W-1:0] prod_r;
  logic signed [bwlp_pkg::FF_PROD_W-1:0] rnd;
  logic signed [bwlp_pkg::ACC_W-1:0]     term_r;

  always_ff @(posedge clk) begin
    if (ctl.ld_prime) begin
      for (int k = 0; k < DEPTH; k++) begin
        smp_r[k] <= x;
      end
    end else if (ctl.ld_sample) begin
      for (int k = DEPTH - 1; k > 0; k--) begin
        smp_r[k] <= smp_r[k-1];
      end
      smp_r[0] <= x;
    end
  end

  // Binomial weights 1, 3, 3, 1 of the third-order numerator.
  always_comb begin
    pair    = bwlp_pkg::SUM_W'(smp_r[1]) + bwlp_pkg::SUM_W'(smp_r[2]);
    sum_nxt = bwlp_pkg::SUM_W'(smp_r[0]) + bwlp_pkg::SUM_W'(smp_r[DEPTH-1])
            + pair + (pair <<< 1);
    prod_nxt = bwlp_pkg::FF_PROD_W'(sum_r) * bwlp_pkg::FF_PROD_W'($signed({1'b0, gain}));
    rnd      = prod_r + FF_HALF;
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_hi) begin
      sum_r <= sum_nxt;
    end
    if (ctl.mul_lo) begin
      prod_r <= prod_nxt;
    end
    if (ctl.rnd_a) begin
      term_r <= bwlp_pkg::ACC_W'(rnd >>> bwlp_pkg::FF_SHIFT);
    end
  end

  assign ff_term = term_r;

endmodule

// ===== design/bwlp_tap_cell.sv =====
// One feedback tap: holds one stored output, multiplies it by its coefficient
// in two halves, rounds, and adds the term to the incoming partial sum.
// Depends on bwlp_pkg.
`timescale 1ns / 1ps

module bwlp_tap_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bwlp_pkg::ctl_t                      ctl,
  input  logic signed [bwlp_pkg::COEF_W-1:0]  coef,
  input  logic signed [bwlp_pkg::HIST_W-1:0]  y_in,
  input  logic signed [bwlp_pkg::HIST_W-1:0]  load_val,
  output logic signed [bwlp_pkg::HIST_W-1:0]  y_out,
  input  logic signed [bwlp_pkg::ACC_W-1:0]   acc_in,
  input  logic                                acc_vld_in,
  output logic signed [bwlp_pkg::ACC_W-1:0]   acc_out,
  output logic                                acc_vld_out
);

  localparam logic signed [bwlp_pkg::REST_W-1:0] REST_HALF =
    bwlp_pkg::REST_W'(1) <<< (bwlp_pkg::RND_SHIFT - 1);

  logic signed [bwlp_pkg::HIST_W-1:0]  y_r;
  logic signed [bwlp_pkg::SPLIT_W:0]   opnd;
  logic signed [bwlp_pkg::MUL_W-1:0]   prod;
  logic signed [bwlp_pkg::MUL_W-1:0]   a_r;
  logic signed [bwlp_pkg::MUL_W-1:0]   b_r;
  logic signed [bwlp_pkg::AH_W-1:0]    ah_r;
  logic signed [bwlp_pkg::REST_W-1:0]  rest_nxt;
  logic signed [bwlp_pkg::REST_W-1:0]  rest_r;
  logic signed [bwlp_pkg::ACC_W-1:0]   term_nxt;
  logic signed [bwlp_pkg::ACC_W-1:0]   term_r;
  logic signed [bwlp_pkg::ACC_W-1:0]   acc_r;
  logic                                acc_vld_r;

  // One shared multiplier: the signed upper half first, then the unsigned lower half.
  always_comb begin
    if (ctl.mul_hi) begin
      opnd = $signed({y_r[bwlp_pkg::HIST_W-1], y_r[bwlp_pkg::HIST_W-1:bwlp_pkg::SPLIT_W]});
    end else begin
      opnd = $signed({1'b0, y_r[bwlp_pkg::SPLIT_W-1:0]});
    end
    prod = bwlp_pkg::MUL_W'(opnd) * bwlp_pkg::MUL_W'(coef);
    // The low bits of the upper product line up just under the rounding point.
    rest_nxt = bwlp_pkg::REST_W'(b_r)
             + $signed({{(bwlp_pkg::REST_W - bwlp_pkg::RND_SHIFT){1'b0}},
                        a_r[bwlp_pkg::AL_W-1:0], {bwlp_pkg::SPLIT_W{1'b0}}})
             + REST_HALF;
    term_nxt = bwlp_pkg::ACC_W'(ah_r) + bwlp_pkg::ACC_W'(rest_r >>> bwlp_pkg::RND_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_prime) begin
      y_r <= load_val;
    end else if (ctl.hist_shift) begin
      y_r <= y_in;
    end
    if (ctl.mul_hi) begin
      a_r <= prod;
    end
    if (ctl.mul_lo) begin
      b_r <= prod;
    end
    if (ctl.rnd_a) begin
      rest_r <= rest_nxt;
      ah_r   <= bwlp_pkg::AH_W'(a_r >>> bwlp_pkg::AL_W);
    end
    if (ctl.rnd_b) begin
      term_r <= term_nxt;
    end
    if (acc_vld_in) begin
      acc_r <= acc_in + term_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= 1'b0;
    end else begin
      acc_vld_r <= acc_vld_in;
    end
  end

  assign y_out       = y_r;
  assign acc_out     = acc_r;
  assign acc_vld_out = acc_vld_r;

endmodule

// ===== design/bwlp_checker.sv =====
// Port-level checker for the low-pass core, attached to the top level by bind.
// Depends on bwlp_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "butterworth_lowpass_with_minimum_detect_core_macros.svh"

module bwlp_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input bwlp_pkg::out_t out_data
);

  logic last_min_r;

  // Minimum flag of the last result taken by the receiver.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_min_r <= 1'b0;
    end else if (out_valid && !out_stall) begin
      last_min_r <= out_data.at_minimum;
    end
  end

  `BWLP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `BWLP_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data), "stalled result changed")
  `BWLP_ASSERT_IMPL(a_reset_empty, $past(!rst_n), !out_valid && !in_stall, "core not empty after reset")
  `BWLP_ASSERT_IMPL(a_min_apart, out_valid && last_min_r, !out_data.at_minimum, "minimum flagged twice in a row")

endmodule

bind butterworth_lowpass_with_minimum_detect_core bwlp_checker u_bwlp_checker (.*);
